/* design/fcm_pkg.sv */
// Shared types and constants for the Fourier cone mask block.
`default_nettype none
package fcm_pkg;

  // Fixed field and datapath widths
  localparam int IDX_W     = 9;
  localparam int ABS_W     = 10;
  localparam int RHO2_W    = 20;
  localparam int DEN_W     = 26;
  localparam int DEN2_W    = 52;
  localparam int QUOT_W    = 21;
  localparam int XQ_W      = 30;
  localparam int EQ_W      = 32;
  localparam int MASK_W    = 17;
  localparam int VAL_W     = 32;
  localparam int SLOPE_W   = 17;
  localparam int BASE_W    = 16;
  localparam int BOX_W     = 10;
  localparam int CFG_IDX_W = 2;

  // Exponential series: Horner terms and final squarings
  localparam int EXP_TERMS     = 12;
  localparam int EXP_SQUARINGS = 5;

  // Decoupling queue depth, pointer width and count width
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [MASK_W-1:0] MASK_ONE = 17'd65536;
  localparam logic [EQ_W-1:0]   Q31_ONE  = 32'h8000_0000;

  // Register reset values
  localparam logic [SLOPE_W-1:0] SLOPE_RESET = 17'd1144;
  localparam logic [BASE_W-1:0]  BASE_RESET  = 16'd256;
  localparam logic [BOX_W-1:0]   BOX_RESET   = 10'd512;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX   = 2'd2;

  // floor(2^32 / n) for n = 1..12, for division by small constants
  localparam logic [32:0] RECIP_TAB [EXP_TERMS+1] = '{
    33'd0,
    33'd4294967296,
    33'd2147483648,
    33'd1431655765,
    33'd1073741824,
    33'd858993459,
    33'd715827882,
    33'd613566756,
    33'd536870912,
    33'd477218588,
    33'd429496729,
    33'd390451572,
    33'd357913941
  };

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic [BASE_W-1:0]  base;
    logic [BOX_W-1:0]   box;
  } cfg_t;

  // One classified voxel, as held in the queue
  typedef struct packed {
    logic [RHO2_W-1:0]       rho2;
    logic [DEN_W-1:0]        den;
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
  } item_t;

  // Sideband that travels with the quotient and the exponential
  typedef struct packed {
    logic                    sat;
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
  } tag_t;

endpackage
`default_nettype wire

/* design/fourier_cone_mask.sv */
// Top level of the Fourier-space cone mask.
//
// Usage: one voxel per transaction. Present freq_x, row_y, slice_z, value_re
// and value_im with start high; the voxel is taken at a rising edge where
// start is high and busy is low. The front end wraps indices and forms
// rho^2 and the cone radius into a four-entry queue; the back end squares the
// radius, divides one quotient bit per stage, evaluates the exponential as a
// twelve-step Horner series (three stages per step) and five squarings, then
// scales the coefficient.
// Output: done is high for one cycle, with masked_re, masked_im and
// mask_weight valid in that cycle.
// Throughput: one voxel per cycle; every stage is a register pipeline, so
// the back end drains the queue each cycle and busy stays low in steady use.
// Results cannot be held off: the receiver takes each one in its done cycle.
// Configuration: cfg_index selects cone_slope (0), base_radius (1) or
// box_size (2); cfg_ready is always high; write only while no voxel is in
// flight. Index 3 is ignored.
// Reset (rst, synchronous): empties the queue and pipeline, restores
// cone_slope 1144, base_radius 256, box_size 512.
`default_nettype none
module fourier_cone_mask #(
  parameter int MAX_BOX = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [fcm_pkg::IDX_W-1:0]            freq_x,
  input  logic [fcm_pkg::IDX_W-1:0]            row_y,
  input  logic [fcm_pkg::IDX_W-1:0]            slice_z,
  input  logic signed [fcm_pkg::VAL_W-1:0]     value_re,
  input  logic signed [fcm_pkg::VAL_W-1:0]     value_im,
  output logic                                 done,
  output logic signed [fcm_pkg::VAL_W-1:0]     masked_re,
  output logic signed [fcm_pkg::VAL_W-1:0]     masked_im,
  output logic [fcm_pkg::MASK_W-1:0]           mask_weight,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fcm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fcm_pkg::SLOPE_W-1:0]          cfg_data
);
  import fcm_pkg::*;

  cfg_t              cfg;
  item_t             front_item;
  item_t             q_item;
  logic              q_valid;
  logic              q_full;
  logic              div_valid;
  logic [QUOT_W-1:0] div_quot;
  tag_t              div_tag;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slope <= SLOPE_RESET;
      cfg.base  <= BASE_RESET;
      cfg.box   <= BOX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLOPE: cfg.slope <= cfg_data;
        REG_BASE:  cfg.base  <= cfg_data[BASE_W-1:0];
        REG_BOX:   cfg.box   <= cfg_data[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  fcm_front #(
    .MAX_BOX(MAX_BOX)
  ) u_front (
    .cfg      (cfg),
    .freq_x   (freq_x),
    .row_y    (row_y),
    .slice_z  (slice_z),
    .value_re (value_re),
    .value_im (value_im),
    .item     (front_item)
  );

  fcm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start),
    .push_item (front_item),
    .pop       (q_valid),
    .out_valid (q_valid),
    .out_item  (q_item),
    .full      (q_full)
  );

  fcm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_tag   (div_tag)
  );

  fcm_exp u_exp (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (div_valid),
    .in_quot     (div_quot),
    .in_tag      (div_tag),
    .done        (done),
    .masked_re   (masked_re),
    .masked_im   (masked_im),
    .mask_weight (mask_weight)
  );

endmodule
`default_nettype wire

/* design/fcm_front.sv */
// Front end: wraps indices and forms rho squared and the cone radius.
`default_nettype none
module fcm_front #(
  parameter int MAX_BOX = 512
) (
  input  fcm_pkg::cfg_t                    cfg,
  input  logic [fcm_pkg::IDX_W-1:0]        freq_x,
  input  logic [fcm_pkg::IDX_W-1:0]        row_y,
  input  logic [fcm_pkg::IDX_W-1:0]        slice_z,
  input  logic signed [fcm_pkg::VAL_W-1:0] value_re,
  input  logic signed [fcm_pkg::VAL_W-1:0] value_im,
  output fcm_pkg::item_t                   item
);
  import fcm_pkg::*;

  localparam logic [12:0] MAX_BOX_W = 13'(MAX_BOX);

  logic [BOX_W-1:0]  box_eff;
  logic [BASE_W-1:0] d0;
  logic [ABS_W-1:0]  ay;
  logic [ABS_W-1:0]  az;

  // Magnitude of a wrapped index
  function automatic logic [ABS_W-1:0] wrap_abs(input logic [IDX_W-1:0] idx,
                                                input logic [BOX_W-1:0] box);
    logic signed [BOX_W:0] diff;
    logic [BOX_W:0]        mag;
    diff = $signed({2'b00, idx}) - $signed({1'b0, box});
    mag  = diff[BOX_W] ? 11'(-diff) : 11'(diff);
    if (idx < box[BOX_W-1:1]) begin
      wrap_abs = {1'b0, idx};
    end else begin
      wrap_abs = mag[ABS_W-1:0];
    end
  endfunction

  // Clamp box, keep d0 nonzero
  assign box_eff = ({3'b000, cfg.box} > MAX_BOX_W) ? MAX_BOX_W[BOX_W-1:0] : cfg.box;
  assign d0      = (cfg.base == '0) ? BASE_W'(1) : cfg.base;

  assign ay = wrap_abs(row_y, box_eff);
  assign az = wrap_abs(slice_z, box_eff);

  // rho^2 as an integer and D in Q.16
  always_comb begin
    item.rho2 = RHO2_W'(RHO2_W'(freq_x) * RHO2_W'(freq_x)) + RHO2_W'(RHO2_W'(ay) * RHO2_W'(ay));
    item.den  = DEN_W'(DEN_W'(az) * DEN_W'(cfg.slope)) + {2'b00, d0, 8'h00};
    item.re   = value_re;
    item.im   = value_im;
  end

endmodule
`default_nettype wire

/* design/fcm_queue.sv */
// Short queue between the front end and the arithmetic back end.
`default_nettype none
module fcm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fcm_pkg::item_t push_item,
  input  logic           pop,
  output logic           out_valid,
  output fcm_pkg::item_t out_item,
  output logic           full
);
  import fcm_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign out_valid = (count != '0);
  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign out_item  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && out_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* design/fcm_div.sv */
// Saturation test and pipelined restoring division giving t^2 in Q.16.
`default_nettype none
module fcm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  fcm_pkg::item_t              in_item,
  output logic                        out_valid,
  output logic [fcm_pkg::QUOT_W-1:0]  out_quot,
  output fcm_pkg::tag_t               out_tag
);
  import fcm_pkg::*;

  // Stage 0: square the radius
  logic              v0;
  logic [DEN2_W-1:0] den2_0;
  logic [RHO2_W-1:0] rho2_0;
  logic signed [VAL_W-1:0] re0;
  logic signed [VAL_W-1:0] im0;

  // Division stages
  logic              dv    [QUOT_W+1];
  logic [DEN2_W-1:0] rem_s [QUOT_W+1];
  logic [DEN2_W-1:0] dsr_s [QUOT_W+1];
  logic [QUOT_W-1:0] quo_s [QUOT_W+1];
  tag_t              tag_s [QUOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    den2_0 <= DEN2_W'(DEN2_W'(in_item.den) * DEN2_W'(in_item.den));
    rho2_0 <= in_item.rho2;
    re0    <= in_item.re;
    im0    <= in_item.im;
  end

  // Stage 1: saturation flag and initial remainder rho^2 << 27
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    rem_s[0]     <= {5'b00000, rho2_0, 27'd0};
    dsr_s[0]     <= den2_0;
    quo_s[0]     <= '0;
    tag_s[0].sat <= ({5'b00000, rho2_0, 27'd0} >= den2_0);
    tag_s[0].re  <= re0;
    tag_s[0].im  <= im0;
  end

  // One quotient bit per stage
  for (genvar j = 0; j < QUOT_W; j++) begin : g_step
    logic [DEN2_W:0] shifted;
    logic [DEN2_W:0] diff;
    logic            ge;

    assign shifted = {rem_s[j], 1'b0};
    assign diff    = shifted - {1'b0, dsr_s[j]};
    assign ge      = (shifted >= {1'b0, dsr_s[j]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      rem_s[j+1] <= ge ? diff[DEN2_W-1:0] : shifted[DEN2_W-1:0];
      dsr_s[j+1] <= dsr_s[j];
      quo_s[j+1] <= {quo_s[j][QUOT_W-2:0], ge};
      tag_s[j+1] <= tag_s[j];
    end
  end

  assign out_valid = dv[QUOT_W];
  assign out_quot  = quo_s[QUOT_W];
  assign out_tag   = tag_s[QUOT_W];

endmodule
`default_nettype wire

/* design/fcm_exp.sv */
// Back end: exp(-t^2/2) by Horner series and squarings, mask and scaling.
`default_nettype none
module fcm_exp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic [fcm_pkg::QUOT_W-1:0]         in_quot,
  input  fcm_pkg::tag_t                      in_tag,
  output logic                               done,
  output logic signed [fcm_pkg::VAL_W-1:0]   masked_re,
  output logic signed [fcm_pkg::VAL_W-1:0]   masked_im,
  output logic [fcm_pkg::MASK_W-1:0]         mask_weight
);
  import fcm_pkg::*;

  localparam int PROD_W = XQ_W + EQ_W;
  localparam int TERM_W = 31;
  localparam int SC_W   = VAL_W + MASK_W;

  // Horner chain boundaries
  logic [XQ_W-1:0] hx [EXP_TERMS+1];
  logic [EQ_W-1:0] he [EXP_TERMS+1];
  logic            hv [EXP_TERMS+1];
  tag_t            ht [EXP_TERMS+1];

  assign hx[0] = {in_quot, 9'd0};
  assign he[0] = Q31_ONE;
  assign hv[0] = in_valid;
  assign ht[0] = in_tag;

  for (genvar k = 0; k < EXP_TERMS; k++) begin : g_horner
    localparam int N = EXP_TERMS - k;

    logic              a_v;
    logic [PROD_W-1:0] a_prod;
    logic [XQ_W-1:0]   a_x;
    tag_t              a_tag;
    logic              b_v;
    logic [63:0]       b_prod;
    logic [TERM_W-1:0] b_val;
    logic [XQ_W-1:0]   b_x;
    tag_t              b_tag;
    logic [PROD_W-1:0] rnd;
    logic [TERM_W-1:0] term_add;
    logic [TERM_W-1:0] q0;
    logic [TERM_W-1:0] rem;
    logic [TERM_W-1:0] quot;

    // Stage A: x * e
    always_ff @(posedge clk) begin
      a_prod <= PROD_W'(PROD_W'(hx[k]) * PROD_W'(he[k]));
      a_x    <= hx[k];
      a_tag  <= ht[k];
    end

    // Stage B: round at bit 31, add n/2, multiply by reciprocal of n
    assign rnd      = a_prod + (PROD_W'(1) << 30);
    assign term_add = rnd[PROD_W-1:31] + TERM_W'(N / 2);

    always_ff @(posedge clk) begin
      b_prod <= 64'(64'(term_add) * 64'(RECIP_TAB[N]));
      b_val  <= term_add;
      b_x    <= a_x;
      b_tag  <= a_tag;
    end

    // Stage C: correct the estimate by one and form the next e
    assign q0   = b_prod[62:32];
    assign rem  = b_val - TERM_W'(q0 * TERM_W'(N));
    assign quot = (rem >= TERM_W'(N)) ? q0 + TERM_W'(1) : q0;

    always_ff @(posedge clk) begin
      he[k+1] <= Q31_ONE - {1'b0, quot};
      hx[k+1] <= b_x;
      ht[k+1] <= b_tag;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v     <= 1'b0;
        b_v     <= 1'b0;
        hv[k+1] <= 1'b0;
      end else begin
        a_v     <= hv[k];
        b_v     <= a_v;
        hv[k+1] <= b_v;
      end
    end
  end

  // Squaring chain
  logic [EQ_W-1:0] se [EXP_SQUARINGS+1];
  logic            sv [EXP_SQUARINGS+1];
  tag_t            st [EXP_SQUARINGS+1];

  assign se[0] = he[EXP_TERMS];
  assign sv[0] = hv[EXP_TERMS];
  assign st[0] = ht[EXP_TERMS];

  for (genvar s = 0; s < EXP_SQUARINGS; s++) begin : g_square
    logic [63:0] sq;

    assign sq = 64'(64'(se[s]) * 64'(se[s])) + (64'd1 << 30);

    always_ff @(posedge clk) begin
      se[s+1] <= sq[62:31];
      st[s+1] <= st[s];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[s+1] <= 1'b0;
      end else begin
        sv[s+1] <= sv[s];
      end
    end
  end

  // Mask in Q1.16, forced to one on saturation
  logic [EQ_W-1:0]   e_rnd;
  logic              m_v;
  logic [MASK_W-1:0] m_val;
  tag_t              m_tag;

  assign e_rnd = se[EXP_SQUARINGS] + (EQ_W'(1) << 14);

  always_ff @(posedge clk) begin
    m_val <= st[EXP_SQUARINGS].sat ? MASK_ONE : MASK_ONE - e_rnd[EQ_W-1:15];
    m_tag <= st[EXP_SQUARINGS];
  end

  // Magnitude of a two's complement value
  function automatic logic [VAL_W-1:0] mag_of(input logic signed [VAL_W-1:0] raw);
    mag_of = raw[VAL_W-1] ? VAL_W'(~raw + 1'b1) : VAL_W'(raw);
  endfunction

  // Rounded, signed result of magnitude product
  function automatic logic [VAL_W-1:0] finish(input logic [SC_W-1:0] prod,
                                              input logic neg);
    logic [SC_W-1:0] rnd_p;
    logic [VAL_W-1:0] r;
    rnd_p  = prod + (SC_W'(1) << 15);
    r      = rnd_p[VAL_W+15:16];
    finish = neg ? VAL_W'(-r) : r;
  endfunction

  // Scale: magnitude times mask
  logic              p_v;
  logic [SC_W-1:0]   p_re;
  logic [SC_W-1:0]   p_im;
  logic              p_neg_re;
  logic              p_neg_im;
  logic [MASK_W-1:0] p_mask;

  always_ff @(posedge clk) begin
    p_re     <= SC_W'(SC_W'(mag_of(m_tag.re)) * SC_W'(m_val));
    p_im     <= SC_W'(SC_W'(mag_of(m_tag.im)) * SC_W'(m_val));
    p_neg_re <= m_tag.re[VAL_W-1];
    p_neg_im <= m_tag.im[VAL_W-1];
    p_mask   <= m_val;
  end

  // Output register
  always_ff @(posedge clk) begin
    masked_re   <= $signed(finish(p_re, p_neg_re));
    masked_im   <= $signed(finish(p_im, p_neg_im));
    mask_weight <= p_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v  <= 1'b0;
      p_v  <= 1'b0;
      done <= 1'b0;
    end else begin
      m_v  <= sv[EXP_SQUARINGS];
      p_v  <= m_v;
      done <= p_v;
    end
  end

endmodule
`default_nettype wire
